FILE: design/tcw_pkg.sv
// Package for the text console writer: shared constants, command codes,
// payload structs and the types that pass between the front and back parts.
// No dependencies.
package tcw_pkg;

    localparam int unsigned COLUMNS_DEFAULT = 80;
    localparam int unsigned ROWS_DEFAULT    = 25;

    // Depths of the operation queue and the result queue; powers of two.
    localparam int unsigned OPQ_DEPTH  = 2;
    localparam int unsigned RESQ_DEPTH = 2;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'd15;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [15:0] cell_data;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } t_op_entry;

    typedef struct packed {
        logic      valid;
        t_op_entry entry;
    } t_op_port;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

FILE: design/text_console_writer.sv
// Results: put, newline and no-op results are queued when the back part takes the
// operation, a read result from the registered memory read, and a clear or a put or
// newline past the last row when the sweep writes the last cell. Reset: synchronous;
// afterwards the screen is swept to blank cells with full held high; configuration
// writes are taken. Throughput: one put, newline or no-op per cycle while results
// are popped and no sweep runs; a read or a clear holds the back part until done.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int unsigned COLUMNS = COLUMNS_DEFAULT,
    parameter int unsigned ROWS    = ROWS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_in_item,
    output logic       empty,
    input  logic       pop,
    output t_out_item  o_out_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    t_op_port     op;
    logic         op_pop;
    t_back_status status;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_in_item),
        .o_full   (full),
        .i_status (status),
        .o_op     (op),
        .i_op_pop (op_pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (op),
        .o_op_pop    (op_pop),
        .o_status    (status),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule

FILE: design/tcw_front.sv
// Front part of the text console writer: accepts transactions, classifies
// them into operations and holds them in a short queue for the back part.
// Depends on tcw_pkg.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int unsigned COLUMNS = COLUMNS_DEFAULT,
    parameter int unsigned ROWS    = ROWS_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_in_item     i_item,
    output logic         o_full,
    input  t_back_status i_status,
    output t_op_port     o_op,
    input  logic         i_op_pop
);

    localparam int unsigned CellCount = COLUMNS * ROWS;
    localparam int unsigned PW = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
    localparam int unsigned NW = $clog2(OPQ_DEPTH + 1);

    t_op_entry       r_slot [OPQ_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]   r_count,  n_count;
    t_op_entry       entry;
    logic            accept;

    always_comb begin
        entry.char_code    = i_item.char_code;
        entry.cell_address = i_item.cell_address;
        unique case (i_item.command)
            CMD_PUT: begin
                entry.kind = (i_item.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
            end
            CMD_CLEAR: begin
                entry.kind = OP_CLEAR;
            end
            CMD_READ: begin
                // A read beyond the screen returns zero and is handled as a no-op.
                entry.kind = (32'(i_item.cell_address) < CellCount) ? OP_READ : OP_NOP;
            end
            default: begin
                entry.kind = OP_NOP;
            end
        endcase
    end

    assign o_full = (r_count == NW'(OPQ_DEPTH)) || i_status.init_busy;
    assign accept = i_push && !o_full;

    assign o_op.valid = (r_count != '0);
    assign o_op.entry = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = accept   ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = i_op_pop ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count + NW'(accept) - NW'(i_op_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wr_ptr] <= entry;
        end
    end

endmodule

FILE: design/tcw_back.sv
// Back part of the text console writer: screen memory, cursor, clear sweep,
// attribute register and the result queue.
// Depends on tcw_pkg.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int unsigned COLUMNS = COLUMNS_DEFAULT,
    parameter int unsigned ROWS    = ROWS_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    input  t_op_port     i_op,
    output logic         o_op_pop,
    output t_back_status o_status,
    output logic         o_empty,
    input  logic         i_pop,
    output t_out_item    o_item
);

    localparam int unsigned CellCount = COLUMNS * ROWS;
    localparam int unsigned AW = (CellCount > 1) ? $clog2(CellCount) : 1;
    localparam int unsigned CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned PW = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
    localparam int unsigned NW = $clog2(RESQ_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_RUN   = 3'b010,
        ST_READ  = 3'b100
    } t_back_state;

    t_back_state   r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW-1:0] r_row_base, n_row_base;
    logic [AW-1:0] r_sweep_idx, n_sweep_idx;
    logic [7:0]    r_sweep_attr, n_sweep_attr;
    logic          r_sweep_reply, n_sweep_reply;
    logic [7:0]    r_attr;
    logic [15:0]   r_rd_data;
    logic [15:0]   r_mem [CellCount];

    t_out_item     r_res [RESQ_DEPTH];
    logic [PW-1:0] r_res_wr, r_res_rd;
    logic [NW-1:0] r_res_cnt;

    logic          take;
    logic          line_end;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          res_push;
    logic          res_pop;
    logic [15:0]   res_cell;
    t_out_item     res_data;

    assign take     = (r_state == ST_RUN) && i_op.valid && (r_res_cnt != NW'(RESQ_DEPTH));
    assign o_op_pop = take;
    assign rd_addr  = AW'(i_op.entry.cell_address);
    assign line_end = (i_op.entry.kind == OP_NEWLINE) || (r_col == CW'(COLUMNS - 1));

    assign o_status.init_busy = (r_state == ST_SWEEP) && !r_sweep_reply;

    always_comb begin
        n_state       = r_state;
        n_col         = r_col;
        n_row         = r_row;
        n_row_base    = r_row_base;
        n_sweep_idx   = r_sweep_idx;
        n_sweep_attr  = r_sweep_attr;
        n_sweep_reply = r_sweep_reply;
        mem_we        = 1'b0;
        mem_waddr     = r_sweep_idx;
        mem_wdata     = {r_sweep_attr, SPACE_CODE};
        rd_en         = 1'b0;
        res_push      = 1'b0;
        res_cell      = '0;

        unique case (r_state)
            ST_SWEEP: begin
                mem_we = 1'b1;
                if (r_sweep_idx == AW'(CellCount - 1)) begin
                    n_state  = ST_RUN;
                    res_push = r_sweep_reply;
                end else begin
                    n_sweep_idx = r_sweep_idx + AW'(1);
                end
            end
            ST_READ: begin
                res_push = 1'b1;
                res_cell = r_rd_data;
                n_state  = ST_RUN;
            end
            ST_RUN: begin
                if (take) begin
                    unique case (i_op.entry.kind)
                        OP_PUT, OP_NEWLINE: begin
                            if (i_op.entry.kind == OP_PUT) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_row_base + AW'(r_col);
                                mem_wdata = {r_attr, i_op.entry.char_code};
                            end
                            if (!line_end) begin
                                n_col    = r_col + CW'(1);
                                res_push = 1'b1;
                            end else if (r_row == RW'(ROWS - 1)) begin
                                // Running past the last row blanks the screen.
                                n_state       = ST_SWEEP;
                                n_sweep_idx   = '0;
                                n_sweep_attr  = r_attr;
                                n_sweep_reply = 1'b1;
                                n_col         = '0;
                                n_row         = '0;
                                n_row_base    = '0;
                            end else begin
                                n_col      = '0;
                                n_row      = r_row + RW'(1);
                                n_row_base = r_row_base + AW'(COLUMNS);
                                res_push   = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_state       = ST_SWEEP;
                            n_sweep_idx   = '0;
                            n_sweep_attr  = r_attr;
                            n_sweep_reply = 1'b1;
                            n_col         = '0;
                            n_row         = '0;
                            n_row_base    = '0;
                        end
                        OP_READ: begin
                            rd_en   = 1'b1;
                            n_state = ST_READ;
                        end
                        default: begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_comb begin
        res_data.cursor_column = 7'(n_col);
        res_data.cursor_row    = 5'(n_row);
        res_data.cell_data     = res_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SWEEP;
            r_col         <= '0;
            r_row         <= '0;
            r_row_base    <= '0;
            r_sweep_idx   <= '0;
            r_sweep_attr  <= ATTR_RESET;
            r_sweep_reply <= 1'b0;
            r_attr        <= ATTR_RESET;
        end else begin
            r_state       <= n_state;
            r_col         <= n_col;
            r_row         <= n_row;
            r_row_base    <= n_row_base;
            r_sweep_idx   <= n_sweep_idx;
            r_sweep_attr  <= n_sweep_attr;
            r_sweep_reply <= n_sweep_reply;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    // Screen memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign res_pop = i_pop && (r_res_cnt != '0);
    assign o_empty = (r_res_cnt == '0);
    assign o_item  = r_res[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr  <= '0;
            r_res_rd  <= '0;
            r_res_cnt <= '0;
        end else begin
            if (res_push) begin
                r_res_wr <= r_res_wr + PW'(1);
            end
            if (res_pop) begin
                r_res_rd <= r_res_rd + PW'(1);
            end
            r_res_cnt <= r_res_cnt + NW'(res_push) - NW'(res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_res_wr] <= res_data;
        end
    end

endmodule

FILE: design/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int unsigned COLUMNS = COLUMNS_DEFAULT,
    parameter int unsigned ROWS    = ROWS_DEFAULT
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input logic      full,
    input t_in_item  i_in_item,
    input logic      empty,
    input logic      pop,
    input t_out_item o_out_item
);

    // Transactions accepted whose results are not yet delivered.
    logic [3:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 4'(push && !full) - 4'(pop && !empty);
        end
    end

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> full && empty)
        else $error("full and empty not set after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_pend != 4'd0)
        else $error("result shown with no transaction outstanding");

    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (32'(o_out_item.cursor_column) < COLUMNS)
                && (32'(o_out_item.cursor_row) < ROWS))
        else $error("cursor out of screen bounds");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_item))
        else $error("waiting result changed or vanished");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);
